[sv/circular_deque_assert.svh]
// Assertion macros for the deque; clock and reset come from the including module.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define CDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

[sv/cdq_pkg.sv]
package cdq_pkg;

	localparam int DEPTH = 8;

	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] push_value;
	} cdq_req_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic [1:0]         status;
		logic               is_empty;
	} cdq_rsp_t;

	// One operation broadcast to every cell of the chain.
	typedef struct packed {
		logic shift_in;   // push front: every cell takes its left neighbor
		logic shift_out;  // pop front: every cell takes its right neighbor
		logic append;     // push back: first free cell loads the value
		logic trim;       // pop back: last occupied cell empties
	} cdq_ctrl_t;

endpackage

[sv/circular_deque.sv]
// Double-ended queue of DEPTH 32-bit signed elements, held as a row of cells
// ordered from front (cell 0) to back. Busy stays low, so a command may be
// issued on every cycle, and its result appears on rsp with rsp_valid high in
// the cycle after start is seen. The result is marked valid for that single
// cycle only; the receiver must take it then. A push front shifts the whole
// row toward the back, a pop front shifts it toward the front; push back fills
// the first free cell and pop back empties the cell at the tail. A push into a
// full queue reports full and changes nothing; a pop from an empty queue
// reports empty and returns zero.
module circular_deque (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cdq_pkg::cdq_req_t req,
	output logic             rsp_valid,
	output cdq_pkg::cdq_rsp_t rsp
);
	import cdq_pkg::*;

	`include "circular_deque_assert.svh"

	logic signed [31:0] cell_val [DEPTH];
	logic [DEPTH-1:0]   occ;
	logic [DEPTH-1:0]   tail;
	logic signed [31:0] tail_val;
	logic               empty;
	logic               full;
	logic               last_one;
	cdq_ctrl_t          ctrl;
	cdq_rsp_t           rsp_d;
	cdq_rsp_t           rsp_q;
	logic               rsp_valid_q;
	logic               pop_front_go;
	int                 occ_count;

	assign empty    = !occ[0];
	assign full     = occ[DEPTH-1];
	assign last_one = occ[0] && !occ[1];
	assign busy     = 1'b0;

	// Pick the back element: the occupied cell whose right neighbor is free.
	always_comb begin
		tail_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail[i] = occ[i] && ((i == DEPTH - 1) ? 1'b1 : !occ[(i + 1) % DEPTH]);
			if (tail[i]) begin
				tail_val = tail_val | cell_val[i];
			end
		end
	end

	always_comb begin
		ctrl            = '0;
		rsp_d.pop_value = '0;
		rsp_d.status    = ST_OK;
		rsp_d.is_empty  = empty;
		unique case (req.cmd) inside
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					ctrl.shift_in  = (req.cmd == CMD_PUSH_FRONT);
					ctrl.append    = (req.cmd == CMD_PUSH_BACK);
					rsp_d.is_empty = 1'b0;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					ctrl.shift_out  = (req.cmd == CMD_POP_FRONT);
					ctrl.trim       = (req.cmd == CMD_POP_BACK);
					rsp_d.pop_value = (req.cmd == CMD_POP_FRONT) ? cell_val[0] : tail_val;
					rsp_d.is_empty  = last_one;
				end
			end
			default: ;
		endcase
		if (!start) begin
			ctrl = '0;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [31:0] left_val;
		logic               left_occ;
		logic signed [31:0] right_val;
		logic               right_occ;

		if (g == 0) begin : g_head
			assign left_val = req.push_value;
			assign left_occ = 1'b1;
		end else begin : g_mid
			assign left_val = cell_val[g-1];
			assign left_occ = occ[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign right_val = '0;
			assign right_occ = 1'b0;
		end else begin : g_inner
			assign right_val = cell_val[g+1];
			assign right_occ = occ[g+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_value (req.push_value),
			.left_val   (left_val),
			.left_occ   (left_occ),
			.right_val  (right_val),
			.right_occ  (right_occ),
			.val        (cell_val[g]),
			.occ        (occ[g])
		);
	end

	// Register the result of each started command; it is held until the next start.
	always_ff @(posedge clk) begin
		if (start) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= start;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pop_front_go = start && (req.cmd == CMD_POP_FRONT) && occ[0];
	assign occ_count    = $countones(occ);

	`CDQ_ASSERT(a_occ_packed, (occ & (occ + 1'b1)) == '0, "occupancy not packed at the front")
	`CDQ_ASSERT_NEXT(a_rsp_follows, start, rsp_valid, "command without a result")
	`CDQ_ASSERT(a_full_not_empty, !(rsp_valid && rsp.status == ST_FULL && rsp.is_empty), "full on empty")
	`CDQ_ASSERT_NEXT(a_pop_shrinks, pop_front_go, $past(occ_count) == occ_count + 1, "pop miscount")

endmodule

[sv/cdq_cell.sv]
module cdq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cdq_pkg::cdq_ctrl_t ctrl,
	input  logic signed [31:0] push_value,
	input  logic signed [31:0] left_val,
	input  logic               left_occ,
	input  logic signed [31:0] right_val,
	input  logic               right_occ,
	output logic signed [31:0] val,
	output logic               occ
);
	import cdq_pkg::*;

	logic signed [31:0] val_q;
	logic               occ_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_in) begin
			val_q <= left_val;
		end else if (ctrl.shift_out) begin
			val_q <= right_val;
		end else if (ctrl.append && !occ_q && left_occ) begin
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.shift_in) begin
			occ_q <= left_occ;
		end else if (ctrl.shift_out) begin
			occ_q <= right_occ;
		end else if (ctrl.append && !occ_q && left_occ) begin
			occ_q <= 1'b1;
		end else if (ctrl.trim && occ_q && !right_occ) begin
			occ_q <= 1'b0;
		end
	end

	assign val = val_q;
	assign occ = occ_q;

endmodule
